// File: design/bsdl_pkg.sv
// bsdl_pkg: shared types and constants for the bounded sorted deque list unit
// holds command codes, status codes, field widths and the cell control structs
// no dependencies
`timescale 1ns / 1ps

package bsdl_pkg;

    // default number of cells in the list
    localparam int CAPACITY_DEF = 16;

    // field widths
    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    // command codes, code seven is a no-op
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_HEAD   = 3'd0,
        CMD_PUSH_TAIL   = 3'd1,
        CMD_POP_HEAD    = 3'd2,
        CMD_POP_TAIL    = 3'd3,
        CMD_DELETE      = 3'd4,
        CMD_QUERY       = 3'd5,
        CMD_SORT_INSERT = 3'd6
    } t_cmd;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // where a cell sits relative to the current fill level
    typedef struct packed {
        logic first;   // cell is the head slot
        logic used;    // cell holds an entry
        logic tail;    // cell is the first free slot
        logic last;    // cell holds the tail entry
    } t_slot;

    // per-cell update control for the apply cycle
    typedef struct packed {
        logic ins;     // open a gap and store the key
        logic rem;     // close the gap at the chosen slot
        logic at;      // cell is the chosen slot
        logic after;   // cell is at or past the chosen slot
    } t_cell_ctl;

endpackage

// File: design/bsdl_cell.sv
// bsdl_cell: one slot of the list, holds an entry and its search hit flag
// shifts toward head or tail from its neighbors on insert and remove
// depends on bsdl_pkg
`timescale 1ns / 1ps

module bsdl_cell (
    input  logic                           i_clk,
    input  logic                           i_capture,
    input  bsdl_pkg::t_cmd                 i_cmd,
    input  logic [bsdl_pkg::DATA_W-1:0]    i_cmp_key,
    input  logic [bsdl_pkg::DATA_W-1:0]    i_ins_key,
    input  bsdl_pkg::t_slot                i_slot,
    input  bsdl_pkg::t_cell_ctl            i_ctl,
    input  logic [bsdl_pkg::DATA_W-1:0]    i_prev,
    input  logic [bsdl_pkg::DATA_W-1:0]    i_next,
    output logic [bsdl_pkg::DATA_W-1:0]    o_value,
    output logic                           o_hit
);

    logic [bsdl_pkg::DATA_W-1:0] r_value;
    logic [bsdl_pkg::DATA_W-1:0] n_value;
    logic                        r_hit;
    logic                        n_hit;

    // hit flag for the command being taken
    always_comb begin
        case (i_cmd)
            bsdl_pkg::CMD_PUSH_HEAD: n_hit = i_slot.first;
            bsdl_pkg::CMD_POP_HEAD:  n_hit = i_slot.first;
            bsdl_pkg::CMD_PUSH_TAIL: n_hit = i_slot.tail;
            bsdl_pkg::CMD_POP_TAIL:  n_hit = i_slot.last;
            bsdl_pkg::CMD_DELETE:    n_hit = i_slot.used && (r_value == i_cmp_key);
            bsdl_pkg::CMD_QUERY:     n_hit = i_slot.used && (r_value == i_cmp_key);
            bsdl_pkg::CMD_SORT_INSERT: begin
                n_hit = (i_slot.used && ($signed(r_value) >= $signed(i_cmp_key)))
                        || i_slot.tail;
            end
            default: n_hit = 1'b0;
        endcase
    end

    // shift or store on the apply cycle
    always_comb begin
        n_value = r_value;
        if (i_ctl.ins && i_ctl.at) begin
            n_value = i_ins_key;
        end else if (i_ctl.ins && i_ctl.after) begin
            n_value = i_prev;
        end else if (i_ctl.rem && i_ctl.after) begin
            n_value = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_capture) begin
            r_hit <= n_hit;
        end
    end

    assign o_value = r_value;
    assign o_hit   = r_hit;

endmodule

// File: design/bounded_sorted_deque_list_unit.sv
// bounded_sorted_deque_list_unit: top level of the ordered list of signed words
// a row of bsdl_cell slots with shared prefix logic, count and result register
// depends on bsdl_pkg and bsdl_cell
`timescale 1ns / 1ps

// A beat is accepted, then applied: on the accept edge every cell compares
// the operand against its entry and latches a hit flag; on the apply edge a
// prefix OR over the hit flags picks the first hit slot and, on insert or
// remove, the cells at or past it shift in one step toward tail or head.
// o_stall is high while applying, so a new beat waits until the last one is
// applied. The result beat is held in an output register; when it is stalled,
// the apply of the following command waits until the held result is taken.
// The list holds CAPACITY entries, slot 0 is the head; contents need no reset.

module bounded_sorted_deque_list_unit #(
    parameter int CAPACITY = bsdl_pkg::CAPACITY_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [bsdl_pkg::CMD_W-1:0]            i_command,
    input  logic signed [bsdl_pkg::DATA_W-1:0]    i_value,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [bsdl_pkg::DATA_W-1:0]    o_out_value,
    output logic                                  o_found,
    output logic [bsdl_pkg::STATUS_W-1:0]         o_status,
    output logic [bsdl_pkg::ENTRY_COUNT_W-1:0]    o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > bsdl_pkg::ENTRY_COUNT_W) ? CNT_W
                                                            : bsdl_pkg::ENTRY_COUNT_W;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } t_state;

    t_state                                r_state;
    logic [CNT_W-1:0]                      r_count;
    logic [CNT_W-1:0]                      n_count;
    bsdl_pkg::t_cmd                        r_cmd;
    logic [bsdl_pkg::DATA_W-1:0]           r_key;

    logic                                  r_out_valid;
    logic [bsdl_pkg::DATA_W-1:0]           r_out_value;
    logic                                  r_out_found;
    logic [bsdl_pkg::STATUS_W-1:0]         r_out_status;
    logic [bsdl_pkg::ENTRY_COUNT_W-1:0]    r_out_count;

    logic                                  accept;
    logic                                  finish;
    logic                                  full;
    logic                                  empty;
    logic                                  any_hit;
    logic                                  do_ins;
    logic                                  do_rem;
    logic [bsdl_pkg::DATA_W-1:0]           n_out_value;
    logic                                  n_out_found;
    logic [bsdl_pkg::STATUS_W-1:0]         n_out_status;
    logic [EXT_W-1:0]                      count_ext;

    logic [CAPACITY-1:0]                   hit;
    logic [CAPACITY-1:0]                   incl;
    logic [CAPACITY-1:0]                   at_slot;
    logic [CAPACITY-1:0]                   do_update;
    logic [bsdl_pkg::DATA_W-1:0]           sel_value;
    logic [bsdl_pkg::DATA_W-1:0]           cell_val [CAPACITY];

    // handshake
    assign o_stall = (r_state == S_APPLY);
    assign accept  = i_valid && !o_stall;
    assign finish  = (r_state == S_APPLY) && (!r_out_valid || !i_stall);

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        bsdl_pkg::t_slot     slot;
        bsdl_pkg::t_cell_ctl ctl;
        logic [bsdl_pkg::DATA_W-1:0] prev_val;
        logic [bsdl_pkg::DATA_W-1:0] next_val;

        assign slot.first = (g == 0);
        assign slot.used  = (r_count > CNT_W'(g));
        assign slot.tail  = (r_count == CNT_W'(g));
        assign slot.last  = (r_count == CNT_W'(g + 1));

        assign ctl.ins   = do_update[g] && do_ins;
        assign ctl.rem   = do_update[g] && do_rem;
        assign ctl.at    = at_slot[g];
        assign ctl.after = incl[g];

        if (g == 0) begin : g_head
            assign prev_val = '0;
        end else begin : g_body
            assign prev_val = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign next_val = '0;
        end else begin : g_link
            assign next_val = cell_val[g+1];
        end

        bsdl_cell u_cell (
            .i_clk     (i_clk),
            .i_capture (accept),
            .i_cmd     (bsdl_pkg::t_cmd'(i_command)),
            .i_cmp_key (i_value),
            .i_ins_key (r_key),
            .i_slot    (slot),
            .i_ctl     (ctl),
            .i_prev    (prev_val),
            .i_next    (next_val),
            .o_value   (cell_val[g]),
            .o_hit     (hit[g])
        );
    end

    assign do_update = {CAPACITY{finish}};

    // first hit slot by log-step prefix or
    always_comb begin
        incl = hit;
        for (int s = 1; s < CAPACITY; s = s * 2) begin
            incl = incl | (incl << s);
        end
    end
    assign at_slot = incl & ~(incl << 1);
    assign any_hit = |hit;

    // pick the entry at the chosen slot
    always_comb begin
        sel_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sel_value = sel_value | ({bsdl_pkg::DATA_W{at_slot[i]}} & cell_val[i]);
        end
    end

    // command decode for the apply cycle
    assign full  = (r_count == CNT_W'(CAPACITY));
    assign empty = (r_count == '0);

    always_comb begin
        do_ins       = 1'b0;
        do_rem       = 1'b0;
        n_out_value  = '0;
        n_out_found  = 1'b0;
        n_out_status = bsdl_pkg::ST_OK;
        case (r_cmd)
            bsdl_pkg::CMD_PUSH_HEAD, bsdl_pkg::CMD_PUSH_TAIL,
            bsdl_pkg::CMD_SORT_INSERT: begin
                if (full) begin
                    n_out_status = bsdl_pkg::ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            bsdl_pkg::CMD_POP_HEAD, bsdl_pkg::CMD_POP_TAIL: begin
                if (empty) begin
                    n_out_status = bsdl_pkg::ST_EMPTY;
                end else begin
                    do_rem      = 1'b1;
                    n_out_value = sel_value;
                end
            end
            bsdl_pkg::CMD_DELETE: begin
                do_rem      = any_hit;
                n_out_found = any_hit;
            end
            bsdl_pkg::CMD_QUERY: begin
                n_out_found = any_hit;
            end
            default: begin
                do_ins = 1'b0;
            end
        endcase
    end

    // next fill level
    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end
    assign count_ext = EXT_W'(n_count);

    // state, count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result beat replaces the one taken on this edge
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (finish) begin
                        r_state <= S_IDLE;
                        r_count <= n_count;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (accept) begin
            r_cmd <= bsdl_pkg::t_cmd'(i_command);
            r_key <= i_value;
        end
        if (finish) begin
            r_out_value  <= n_out_value;
            r_out_found  <= n_out_found;
            r_out_status <= n_out_status;
            r_out_count  <= count_ext[bsdl_pkg::ENTRY_COUNT_W-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_found       = r_out_found;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

    // fill level stays within the row of cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // at most one slot is chosen for insert or remove
    a_one_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> $onehot0(at_slot))
        else $error("more than one slot chosen");

    // a finished apply cycle presents a result beat
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> o_valid && (r_state == S_IDLE))
        else $error("apply cycle without result beat");

    // a removal never happens on an empty list
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && do_rem) |-> !empty)
        else $error("remove from empty list");

endmodule
